// ===== sv/decimal_parameter_parser_assert.svh =====
// assertion macros shared by the parser modules
// each macro expects clk and rst_n in the enclosing module
`ifndef DECIMAL_PARAMETER_PARSER_ASSERT_SVH
`define DECIMAL_PARAMETER_PARSER_ASSERT_SVH

// a condition that holds at every clock edge out of reset
`define DPP_ASSERT_HOLDS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// a condition that must hold whenever the antecedent is true
`define DPP_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/dpp_pkg.sv =====
`default_nettype none

package dpp_pkg;

    // field widths
    localparam int MAG_W   = 30;
    localparam int EXP_W   = 4;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int VALUE_W = 51;

    // largest magnitude a result may carry
    localparam logic [SUM_W-1:0] MAX_MAG = 61'd999999999999999;

    // value kinds
    localparam logic [1:0] KIND_INT   = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;
    localparam logic [1:0] KIND_BIT   = 2'd3;

    // characters of interest
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // result status codes
    typedef enum logic [2:0] {
        ST_VALUE     = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_BAD_CHAR  = 3'd4
    } status_t;

    // finished field handed from the parser to the scaling stage
    typedef struct packed {
        status_t            status;
        logic               negative;
        logic               ended_by_cr;
        logic [MAG_W-1:0]   int_mag;
        logic [EXP_W-1:0]   int_exp;
        logic [MAG_W-1:0]   frac_mag;
        logic [EXP_W-1:0]   frac_exp;
    } req_t;

    // scaled partial magnitudes handed to the output stage
    typedef struct packed {
        status_t            status;
        logic               negative;
        logic               ended_by_cr;
        logic [PROD_W-1:0]  int_prod;
        logic [PROD_W-1:0]  frac_prod;
    } prod_t;

    // power of ten, exponents above nine saturate
    function automatic logic [MAG_W-1:0] pow10(input logic [EXP_W-1:0] n);
        logic [MAG_W-1:0] p;
        unique case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== sv/dpp_parse.sv =====
`default_nettype none
`include "decimal_parameter_parser_assert.svh"

module dpp_parse #(
    parameter int INT_DIGIT_LIMIT       = 9,
    parameter int FIXED_INT_DIGIT_LIMIT = 6,
    parameter int SHORT_FRAC_DIGITS     = 6,
    parameter int FULL_FRAC_DIGITS      = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          s_tlast,
    output logic          req_valid,
    output dpp_pkg::req_t req,
    input  logic          dn_ready
);
    import dpp_pkg::*;

    typedef enum logic [4:0] {
        PH_START   = 5'b00001,
        PH_INT     = 5'b00010,
        PH_FRAC    = 5'b00100,
        PH_BIT     = 5'b01000,
        PH_DISCARD = 5'b10000
    } phase_t;

    localparam logic [EXP_W-1:0] INT_LIM   = EXP_W'(INT_DIGIT_LIMIT);
    localparam logic [EXP_W-1:0] FIXED_LIM = EXP_W'(FIXED_INT_DIGIT_LIMIT);
    localparam logic [EXP_W-1:0] SHORT_FW  = EXP_W'(SHORT_FRAC_DIGITS);
    localparam logic [EXP_W-1:0] FULL_FW   = EXP_W'(FULL_FRAC_DIGITS);
    localparam logic [EXP_W-1:0] CNT_MAX   = 4'd9;

    // input word register
    logic             in_valid_reg;
    logic [7:0]       ch_reg;
    logic [1:0]       kind_reg;
    logic             last_reg;

    // field state
    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [MAG_W-1:0] int_reg, int_next;
    logic [MAG_W-1:0] frac_reg, frac_next;
    logic [EXP_W-1:0] cnt_reg, cnt_next;

    // request register
    logic             req_valid_reg;
    req_t             req_reg, req_next;

    // character decode
    logic             is_cr, is_term, is_digit, is_bit_ch, fixed;
    logic [7:0]       sep;
    logic [3:0]       dval;
    logic [EXP_W-1:0] fw, cnt_inc;

    // step outcome
    logic             emit, clr, discard, run_int, consume, dn_ok;

    assign sep       = last_reg ? CH_SEMI : CH_COMMA;
    assign is_cr     = (ch_reg == CH_CR);
    assign is_term   = is_cr || (ch_reg == sep);
    assign is_digit  = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_bit_ch = (ch_reg == CH_ZERO) || (ch_reg == CH_ONE);
    assign dval      = ch_reg[3:0];
    assign fixed     = (kind_reg == KIND_SHORT) || (kind_reg == KIND_FULL);
    assign fw        = (kind_reg == KIND_SHORT) ? SHORT_FW : FULL_FW;
    assign cnt_inc   = cnt_reg + 4'd1;

    // one character against the field state
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        clr        = 1'b0;
        discard    = 1'b0;
        run_int    = 1'b0;
        req_next   = '0;
        req_next.status   = ST_VALUE;
        req_next.negative = neg_reg;

        unique case (phase_reg)
            PH_START:
            begin
                if (is_term)
                begin
                    emit = 1'b1;
                    clr  = 1'b1;
                    req_next.status      = ST_EMPTY;
                    req_next.ended_by_cr = is_cr;
                end
                else if (kind_reg == KIND_BIT)
                begin
                    if (is_bit_ch)
                    begin
                        int_next   = {{(MAG_W-1){1'b0}}, ch_reg[0]};
                        phase_next = PH_BIT;
                    end
                    else
                    begin
                        emit = 1'b1;
                        clr  = 1'b1;
                        discard = 1'b1;
                        req_next.status = ST_BAD_TYPE;
                    end
                end
                else if (ch_reg == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_INT;
                end
                else
                begin
                    run_int = 1'b1;
                end
            end
            PH_INT:
            begin
                run_int = 1'b1;
            end
            PH_FRAC:
            begin
                if ((kind_reg == KIND_INT) || (kind_reg == KIND_BIT))
                begin
                    emit = 1'b1;
                    clr  = 1'b1;
                    discard = !is_term;
                    req_next.status = ST_BAD_TYPE;
                end
                else if (is_term)
                begin
                    emit = 1'b1;
                    clr  = 1'b1;
                    if (cnt_reg > fw)
                    begin
                        req_next.status = ST_BAD_CHAR;
                    end
                    else
                    begin
                        req_next.ended_by_cr = is_cr;
                        req_next.int_mag     = int_reg;
                        req_next.int_exp     = fw;
                        req_next.frac_mag    = frac_reg;
                        req_next.frac_exp    = fw - cnt_reg;
                    end
                end
                else if (is_digit && (cnt_reg < fw))
                begin
                    frac_next = MAG_W'(frac_reg * 30'd10) + {26'b0, dval};
                    cnt_next  = cnt_inc;
                end
                else
                begin
                    emit = 1'b1;
                    clr  = 1'b1;
                    discard = 1'b1;
                    req_next.status = ST_BAD_CHAR;
                end
            end
            PH_BIT:
            begin
                emit = 1'b1;
                clr  = 1'b1;
                if (is_term)
                begin
                    req_next.ended_by_cr = is_cr;
                    req_next.int_mag     = {{(MAG_W-1){1'b0}}, int_reg[0]};
                end
                else
                begin
                    discard = 1'b1;
                    req_next.status = ST_BAD_TYPE;
                end
            end
            PH_DISCARD:
            begin
                if (is_term)
                begin
                    clr = 1'b1;
                end
                else
                begin
                    discard = 1'b1;
                end
            end
            default:
            begin
                clr = 1'b1;
            end
        endcase

        // integer digits, shared by the start and integer phases
        if (run_int)
        begin
            phase_next = PH_INT;
            if (kind_reg == KIND_BIT)
            begin
                emit = 1'b1;
                clr  = 1'b1;
                discard = !is_term;
                req_next.status = ST_BAD_TYPE;
            end
            else if (is_digit)
            begin
                if (fixed && (cnt_inc > FIXED_LIM))
                begin
                    emit = 1'b1;
                    clr  = 1'b1;
                    discard = 1'b1;
                    req_next.status = ST_BAD_TYPE;
                end
                else if (cnt_inc > INT_LIM)
                begin
                    emit = 1'b1;
                    clr  = 1'b1;
                    discard = 1'b1;
                    req_next.status = ST_TOO_LARGE;
                end
                else
                begin
                    int_next = MAG_W'(int_reg * 30'd10) + {26'b0, dval};
                    cnt_next = cnt_inc;
                end
            end
            else if (is_term)
            begin
                emit = 1'b1;
                clr  = 1'b1;
                if ((cnt_reg == 4'd0) || (fixed && (cnt_reg > FIXED_LIM)))
                begin
                    req_next.status = ST_BAD_TYPE;
                end
                else
                begin
                    req_next.ended_by_cr = is_cr;
                    req_next.int_mag     = int_reg;
                    req_next.int_exp     = fixed ? fw : 4'd0;
                end
            end
            else if ((ch_reg == CH_POINT) && fixed && (cnt_reg <= FIXED_LIM))
            begin
                phase_next = PH_FRAC;
                cnt_next   = 4'd0;
            end
            else
            begin
                emit = 1'b1;
                clr  = 1'b1;
                discard = 1'b1;
                req_next.status = (ch_reg == CH_POINT) ? ST_BAD_TYPE : ST_BAD_CHAR;
            end
        end

        // any result or terminator clears the field; an error inside it leads to the discard phase, else to the start
        if (clr)
        begin
            phase_next = discard ? PH_DISCARD : PH_START;
            neg_next   = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            cnt_next   = '0;
        end
    end

    // handshake: a word with no result never waits on downstream
    assign dn_ok    = !req_valid_reg || dn_ready;
    assign consume  = in_valid_reg && (dn_ok || !emit);
    assign s_tready = !in_valid_reg || consume;

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ch_reg   <= s_tdata;
            kind_reg <= s_tuser;
            last_reg <= s_tlast;
        end
    end

    // field state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (consume)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (dn_ok)
        begin
            req_valid_reg <= consume && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dn_ok)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    // checks
    `DPP_ASSERT_IMPLIES(a_start_clear, phase_reg == PH_START,
        (int_reg == '0) && (frac_reg == '0) && (cnt_reg == '0) && !neg_reg,
        "field state not clear at start of field")
    `DPP_ASSERT_HOLDS(a_cnt_range, cnt_reg <= CNT_MAX, "digit count out of range")
    `DPP_ASSERT_IMPLIES(a_err_no_mag, req_valid_reg && (req_reg.status != ST_VALUE),
        (req_reg.int_mag == '0) && (req_reg.frac_mag == '0),
        "error request carries a magnitude")

endmodule

`default_nettype wire

// ===== sv/dpp_scale.sv =====
`default_nettype none

module dpp_scale (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  dpp_pkg::req_t  req,
    output logic           prod_valid,
    output dpp_pkg::prod_t prod,
    input  logic           dn_ready
);
    import dpp_pkg::*;

    logic  prod_valid_reg;
    prod_t prod_reg, prod_next;

    // scale integer and fraction parts by their powers of ten
    always_comb
    begin
        prod_next.status      = req.status;
        prod_next.negative    = req.negative;
        prod_next.ended_by_cr = req.ended_by_cr;
        prod_next.int_prod    = req.int_mag * pow10(req.int_exp);
        prod_next.frac_prod   = req.frac_mag * pow10(req.frac_exp);
    end

    assign req_ready = !prod_valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            prod_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

`default_nettype wire

// ===== sv/dpp_out.sv =====
`default_nettype none
`include "decimal_parameter_parser_assert.svh"

module dpp_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           prod_valid,
    output logic           prod_ready,
    input  dpp_pkg::prod_t prod,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [55:0]    m_tdata,
    output logic [3:0]     m_tuser
);
    import dpp_pkg::*;

    logic               out_valid_reg;
    status_t            status_reg, status_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               cr_reg, cr_next;
    logic [SUM_W-1:0]   sum;
    logic [VALUE_W-1:0] mag;

    // sum, range check and sign
    assign sum = {1'b0, prod.int_prod} + {1'b0, prod.frac_prod};
    assign mag = sum[VALUE_W-1:0];

    always_comb
    begin
        status_next = prod.status;
        cr_next     = prod.ended_by_cr;
        value_next  = '0;
        if (prod.status == ST_VALUE)
        begin
            if (sum > MAX_MAG)
            begin
                status_next = ST_TOO_LARGE;
                cr_next     = 1'b0;
            end
            else
            begin
                value_next = prod.negative ? (VALUE_W'(0) - mag) : mag;
            end
        end
    end

    assign prod_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            out_valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            cr_reg     <= cr_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(56-VALUE_W){1'b0}}, value_reg};
    assign m_tuser  = {cr_reg, status_reg};

    // checks
    `DPP_ASSERT_IMPLIES(a_err_zero_value, out_valid_reg && (status_reg != ST_VALUE),
        value_reg == '0, "error word carries a nonzero value")
    `DPP_ASSERT_IMPLIES(a_cr_status, out_valid_reg && cr_reg,
        (status_reg == ST_VALUE) || (status_reg == ST_EMPTY),
        "carriage return flag on an error word")

endmodule

`default_nettype wire

// ===== sv/decimal_parameter_parser.sv =====
// Decimal argument parser.
// Input stream: one ASCII character per word. s_tdata carries the
// character, s_tuser the value kind (integer, short fixed, full fixed,
// bit) and s_tlast selects the separator (';' when high, ',' when low).
// Output stream: one word per finished field. m_tdata carries the signed
// value scaled by the kind, m_tuser the status code and whether a
// carriage return ended the field. Characters inside a field give no
// output word unless they end it with an error.
// Throughput: one character per cycle while s_tready is high. A result
// reaches m_tvalid through the input register, the parse register, the
// power-of-ten multiply register and the sum-and-sign output register.
// Reset: all stages empty, field state back to the start of a field.
// Stall: each stage holds while the next is full; the parser keeps taking
// characters that give no result while the output waits, and s_tready
// drops only once a result would overwrite a full stage.
`default_nettype none

module decimal_parameter_parser #(
    parameter int INT_DIGIT_LIMIT       = 9,
    parameter int FIXED_INT_DIGIT_LIMIT = 6,
    parameter int SHORT_FRAC_DIGITS     = 6,
    parameter int FULL_FRAC_DIGITS      = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic [1:0]  s_tuser,   // value_kind[1:0]
    input  logic        s_tlast,   // last_param
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // value[50:0], zero[55:51]
    output logic [3:0]  m_tuser    // status[2:0], ended_by_cr[3]
);
    import dpp_pkg::*;

    logic  req_valid, req_ready;
    req_t  req;
    logic  prod_valid, prod_ready;
    prod_t prod;

    // character parser and field state
    dpp_parse #(
        .INT_DIGIT_LIMIT       (INT_DIGIT_LIMIT),
        .FIXED_INT_DIGIT_LIMIT (FIXED_INT_DIGIT_LIMIT),
        .SHORT_FRAC_DIGITS     (SHORT_FRAC_DIGITS),
        .FULL_FRAC_DIGITS      (FULL_FRAC_DIGITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .req_valid (req_valid),
        .req       (req),
        .dn_ready  (req_ready)
    );

    // power-of-ten scaling
    dpp_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .prod_valid (prod_valid),
        .prod       (prod),
        .dn_ready   (prod_ready)
    );

    // sum, range check, sign and output register
    dpp_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_decimal_parameter_parser.sv =====
`default_nettype none

module tb_decimal_parameter_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import dpp_pkg::*;

    // parser limits, same as the block defaults
    localparam int INT_LIMIT       = 9;
    localparam int FIXED_INT_LIMIT = 6;
    localparam int SHORT_FRAC      = 6;
    localparam int FULL_FRAC       = 9;

    localparam longint unsigned MAG_LIMIT = 64'd999999999999999;
    localparam int RANDOM_CHARS = 1075;

    // where the field parser is within one argument
    typedef enum logic [2:0] {
        PH_START,
        PH_INT,
        PH_FRAC,
        PH_BIT,
        PH_DISCARD
    } field_phase_t;

    typedef struct {
        status_t            status;
        logic signed [50:0] value;
        logic               ended_by_cr;
    } field_result_t;

    // one directed argument string, all characters of one kind but at most one
    typedef struct {
        string      text;
        logic [1:0] kind;
        int         alt_at;
        logic [1:0] alt_kind;
        logic       last;
        bit         typed;
        status_t    status;
        longint     value;
        logic       ended_by_cr;
    } arg_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [3:0]  m_tuser;

    // shadow copy of the field state
    field_phase_t fld_phase;
    logic         fld_neg;
    logic [29:0]  fld_int;
    logic [29:0]  fld_frac;
    logic [3:0]   fld_digits;

    field_result_t field_results_q[$];
    arg_row_t      arg_rows[$];

    int          errors = 0;
    int          chars_sent = 0;
    bit          calm = 1'b0;
    int unsigned rx_hold = 0;

    decimal_parameter_parser i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // fixed-point scale factor, saturating at 1e9
    function automatic longint unsigned ten_pow(input int n);
        longint unsigned p;
        int k;
        p = 1;
        for (k = 0; k < n && k < 9; k++)
            p = p * 10;
        return p;
    endfunction

    function automatic void fld_clear();
        fld_phase  = PH_START;
        fld_neg    = 1'b0;
        fld_int    = '0;
        fld_frac   = '0;
        fld_digits = '0;
    endfunction

    // error result; an error inside the field drops the rest of it
    function automatic bit fld_fail(input status_t st, input bit term,
                                    output field_result_t res);
        fld_clear();
        if (!term)
            fld_phase = PH_DISCARD;
        res.status      = st;
        res.value       = '0;
        res.ended_by_cr = 1'b0;
        return 1'b1;
    endfunction

    function automatic bit fld_finish(input longint unsigned mag, input bit cr,
                                      output field_result_t res);
        longint unsigned v;
        if (mag > MAG_LIMIT)
            return fld_fail(ST_TOO_LARGE, 1'b1, res);
        v = fld_neg ? (~mag + 64'd1) : mag;
        res.status      = ST_VALUE;
        res.value       = v[50:0];
        res.ended_by_cr = cr;
        fld_clear();
        return 1'b1;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // integer part of a numeric field
    function automatic bit parse_int_char(input logic [7:0] c, input logic [1:0] kind,
                                          input bit term, input bit cr,
                                          output field_result_t res);
        bit         fixed;
        int         fw;
        logic [3:0] cnt;
        fixed = (kind == KIND_SHORT) || (kind == KIND_FULL);
        fw    = (kind == KIND_SHORT) ? SHORT_FRAC : FULL_FRAC;
        if (kind == KIND_BIT)
            return fld_fail(ST_BAD_TYPE, term, res);
        if (is_digit(c))
        begin
            cnt = fld_digits + 4'd1;
            if (fixed && cnt > FIXED_INT_LIMIT)
                return fld_fail(ST_BAD_TYPE, 1'b0, res);
            if (cnt > INT_LIMIT)
                return fld_fail(ST_TOO_LARGE, 1'b0, res);
            fld_int    = 30'(fld_int * 10 + (c - CH_ZERO));
            fld_digits = cnt;
            return 1'b0;
        end
        if (term)
        begin
            if (fld_digits == 0)
                return fld_fail(ST_BAD_TYPE, 1'b1, res);
            if (fixed && fld_digits > FIXED_INT_LIMIT)
                return fld_fail(ST_BAD_TYPE, 1'b1, res);
            if (!fixed)
                return fld_finish(64'(fld_int), cr, res);
            return fld_finish(64'(fld_int) * ten_pow(fw), cr, res);
        end
        if (c == CH_POINT)
        begin
            if (!fixed || fld_digits > FIXED_INT_LIMIT)
                return fld_fail(ST_BAD_TYPE, 1'b0, res);
            fld_phase  = PH_FRAC;
            fld_digits = '0;
            return 1'b0;
        end
        return fld_fail(ST_BAD_CHAR, 1'b0, res);
    endfunction

    // fraction part, zero-padded to the kind's width at the end
    function automatic bit parse_frac_char(input logic [7:0] c, input logic [1:0] kind,
                                           input bit term, input bit cr,
                                           output field_result_t res);
        int fw;
        fw = (kind == KIND_SHORT) ? SHORT_FRAC : FULL_FRAC;
        if (kind == KIND_INT || kind == KIND_BIT)
            return fld_fail(ST_BAD_TYPE, term, res);
        if (term)
        begin
            if (fld_digits > fw)
                return fld_fail(ST_BAD_CHAR, 1'b1, res);
            return fld_finish(64'(fld_int) * ten_pow(fw)
                              + 64'(fld_frac) * ten_pow(fw - fld_digits), cr, res);
        end
        if (is_digit(c))
        begin
            if (fld_digits >= fw)
                return fld_fail(ST_BAD_CHAR, 1'b0, res);
            fld_frac   = 30'(fld_frac * 10 + (c - CH_ZERO));
            fld_digits = fld_digits + 4'd1;
            return 1'b0;
        end
        return fld_fail(ST_BAD_CHAR, 1'b0, res);
    endfunction

    // advance the shadow parser by one character, 1 when a field result comes out
    function automatic bit parse_char(input logic [7:0] c, input logic [1:0] kind,
                                      input logic last, output field_result_t res);
        logic [7:0] sep;
        bit         cr;
        bit         term;
        sep  = last ? CH_SEMI : CH_COMMA;
        cr   = (c == CH_CR);
        term = cr || (c == sep);
        res.status      = ST_VALUE;
        res.value       = '0;
        res.ended_by_cr = 1'b0;
        case (fld_phase)
            PH_START:
            begin
                if (term)
                begin
                    fld_clear();
                    res.status      = ST_EMPTY;
                    res.ended_by_cr = cr;
                    return 1'b1;
                end
                if (kind == KIND_BIT)
                begin
                    if (c == CH_ZERO || c == CH_ONE)
                    begin
                        fld_int   = 30'(c - CH_ZERO);
                        fld_phase = PH_BIT;
                        return 1'b0;
                    end
                    return fld_fail(ST_BAD_TYPE, 1'b0, res);
                end
                fld_phase = PH_INT;
                if (c == CH_MINUS)
                begin
                    fld_neg = 1'b1;
                    return 1'b0;
                end
                return parse_int_char(c, kind, term, cr, res);
            end
            PH_INT:
                return parse_int_char(c, kind, term, cr, res);
            PH_FRAC:
                return parse_frac_char(c, kind, term, cr, res);
            PH_BIT:
            begin
                if (term)
                begin
                    res.value       = 51'(fld_int[0]);
                    res.ended_by_cr = cr;
                    fld_clear();
                    return 1'b1;
                end
                return fld_fail(ST_BAD_TYPE, 1'b0, res);
            end
            default:
            begin
                if (term)
                    fld_clear();
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void add_row(input string text, input logic [1:0] kind,
                                    input int alt_at, input logic [1:0] alt_kind,
                                    input logic last, input bit typed,
                                    input status_t st, input longint value,
                                    input logic cr);
        arg_row_t row;
        row.text        = text;
        row.kind        = kind;
        row.alt_at      = alt_at;
        row.alt_kind    = alt_kind;
        row.last        = last;
        row.typed       = typed;
        row.status      = st;
        row.value       = value;
        row.ended_by_cr = cr;
        arg_rows.push_back(row);
    endfunction

    // one character word; a typed result, if still pending, replaces the predicted one
    task automatic send_char(input logic [7:0] c, input logic [1:0] kind, input logic last,
                             inout bit use_typed, input field_result_t typed);
        int unsigned   gap;
        field_result_t res;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 2'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= kind;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (parse_char(c, kind, last, res))
        begin
            if (use_typed)
            begin
                res       = typed;
                use_typed = 1'b0;
            end
            field_results_q.push_back(res);
        end
        chars_sent++;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (field_results_q.size() > 0)
            @(posedge clk);
    endtask

    // mostly well-formed arguments, some with one bad character or kind, some noise
    task automatic send_random_field();
        logic [7:0]    fchars[$];
        logic [1:0]    fkinds[$];
        logic [1:0]    kind;
        logic          last;
        int unsigned   mode;
        int unsigned   nd;
        int unsigned   lim;
        int unsigned   fw;
        int unsigned   p;
        bit            nines;
        bit            no_typed;
        field_result_t unused;
        kind  = 2'($urandom_range(0, 3));
        last  = 1'($urandom_range(0, 1));
        mode  = $urandom_range(0, 99);
        nines = ($urandom_range(0, 7) == 0);
        if (mode < 10)
        begin
            repeat ($urandom_range(1, 6))
            begin
                fchars.push_back(8'($urandom_range(0, 255)));
                fkinds.push_back(2'($urandom_range(0, 3)));
            end
        end
        else
        begin
            if (kind == KIND_BIT)
            begin
                if ($urandom_range(0, 9) != 0)
                    fchars.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    fchars.push_back(CH_MINUS);
                lim = (kind == KIND_INT) ? INT_LIMIT : FIXED_INT_LIMIT;
                nd  = ($urandom_range(0, 15) == 0) ? lim + 1
                      : $urandom_range((kind == KIND_INT) ? 1 : 0, lim);
                repeat (nd)
                    fchars.push_back(nines ? CH_NINE
                                     : CH_ZERO + 8'($urandom_range(0, 9)));
                if (kind != KIND_INT && $urandom_range(0, 3) != 0)
                begin
                    fw = (kind == KIND_SHORT) ? SHORT_FRAC : FULL_FRAC;
                    fchars.push_back(CH_POINT);
                    nd = ($urandom_range(0, 15) == 0) ? fw + 1 : $urandom_range(0, fw);
                    repeat (nd)
                        fchars.push_back(nines ? CH_NINE
                                         : CH_ZERO + 8'($urandom_range(0, 9)));
                end
            end
            fchars.push_back(($urandom_range(0, 3) == 0) ? CH_CR
                             : (last ? CH_SEMI : CH_COMMA));
            foreach (fchars[i])
                fkinds.push_back(kind);
            // broken argument: one character or one kind replaced
            if (mode < 20)
            begin
                p = $urandom_range(0, fchars.size() - 1);
                if ($urandom_range(0, 1))
                    fchars[p] = 8'($urandom_range(0, 255));
                else
                    fkinds[p] = 2'($urandom_range(0, 3));
            end
        end
        foreach (fchars[i])
        begin
            no_typed = 1'b0;
            send_char(fchars[i], fkinds[i], last, no_typed, unused);
        end
    endtask

    // receiver: random hold after each word
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            rx_hold = calm ? 0 : $urandom_range(0, 8);
        else if (rx_hold > 0)
            rx_hold = rx_hold - 1;
        m_tready <= rst_n && (rx_hold == 0);
    end

    // compare each output word with the oldest predicted field result
    always @(posedge clk)
    begin
        field_result_t      want;
        logic signed [50:0] got_val;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_val = m_tdata[50:0];
            if (field_results_q.size() == 0)
            begin
                $display("%0t unexpected word: status %0d value %0d cr %0b",
                         $time, m_tuser[2:0], got_val, m_tuser[3]);
                errors++;
            end
            else
            begin
                want = field_results_q.pop_front();
                if (m_tuser[2:0] !== want.status)
                begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, want.status, m_tuser[2:0]);
                    errors++;
                end
                if (got_val !== want.value)
                begin
                    $display("%0t value mismatch: expected %0d actual %0d",
                             $time, $signed(want.value), got_val);
                    errors++;
                end
                if (m_tuser[3] !== want.ended_by_cr)
                begin
                    $display("%0t ended_by_cr mismatch: expected %0b actual %0b",
                             $time, want.ended_by_cr, m_tuser[3]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        field_result_t typed;
        bit            use_typed;
        bit            paused;
        int            wait_cnt;
        logic [1:0]    k;

        fld_clear();
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty fields and extremes
        add_row(",",               KIND_INT,   -1, KIND_INT,   1'b0, 1, ST_EMPTY, 0, 1'b0);
        add_row("\015",            KIND_SHORT, -1, KIND_INT,   1'b0, 1, ST_EMPTY, 0, 1'b1);
        add_row(";",               KIND_BIT,   -1, KIND_INT,   1'b1, 1, ST_EMPTY, 0, 1'b0);
        add_row("999999999;",      KIND_INT,   -1, KIND_INT,   1'b1, 1, ST_VALUE,
                999999999, 1'b0);
        add_row("-999999999\015",  KIND_INT,   -1, KIND_INT,   1'b0, 1, ST_VALUE,
                -999999999, 1'b1);
        add_row("999999.999999;",  KIND_SHORT, -1, KIND_INT,   1'b1, 1, ST_VALUE,
                64'sd999999999999, 1'b0);
        add_row("-999999.999999999,", KIND_FULL, -1, KIND_INT, 1'b0, 1, ST_VALUE,
                -64'sd999999999999999, 1'b0);
        add_row("0.000000001;",    KIND_FULL,  -1, KIND_INT,   1'b1, 0, ST_VALUE, 0, 1'b0);
        add_row("12.5,",           KIND_FULL,  -1, KIND_INT,   1'b0, 0, ST_VALUE, 0, 1'b0);
        // errors and the cases around them
        add_row("1234567890,",     KIND_INT,   -1, KIND_INT,   1'b0, 1, ST_TOO_LARGE, 0, 1'b0);
        add_row("1234567890\015",  KIND_INT,   -1, KIND_INT,   1'b0, 1, ST_TOO_LARGE, 0, 1'b0);
        add_row("-,",              KIND_INT,   -1, KIND_INT,   1'b0, 1, ST_BAD_TYPE, 0, 1'b0);
        add_row(".,",              KIND_SHORT, -1, KIND_INT,   1'b0, 1, ST_VALUE, 0, 1'b0);
        add_row("1.5,",            KIND_INT,   -1, KIND_INT,   1'b0, 1, ST_BAD_TYPE, 0, 1'b0);
        add_row("1234567,",        KIND_SHORT, -1, KIND_INT,   1'b0, 1, ST_BAD_TYPE, 0, 1'b0);
        add_row("1.1234567,",      KIND_SHORT, -1, KIND_INT,   1'b0, 1, ST_BAD_CHAR, 0, 1'b0);
        add_row("7x,",             KIND_INT,   -1, KIND_INT,   1'b0, 1, ST_BAD_CHAR, 0, 1'b0);
        add_row("7;,",             KIND_INT,   -1, KIND_INT,   1'b0, 1, ST_BAD_CHAR, 0, 1'b0);
        // bit kind
        add_row("2,",              KIND_BIT,   -1, KIND_INT,   1'b0, 1, ST_BAD_TYPE, 0, 1'b0);
        add_row("1\015",           KIND_BIT,   -1, KIND_INT,   1'b0, 1, ST_VALUE, 1, 1'b1);
        add_row("10,",             KIND_BIT,   -1, KIND_INT,   1'b0, 1, ST_BAD_TYPE, 0, 1'b0);
        // kind changes inside a field
        add_row("0,",              KIND_BIT,    1, KIND_INT,   1'b0, 0, ST_VALUE, 0, 1'b0);
        add_row("42,",             KIND_INT,    1, KIND_BIT,   1'b0, 0, ST_VALUE, 0, 1'b0);
        add_row("1234567,",        KIND_INT,    7, KIND_SHORT, 1'b0, 1, ST_BAD_TYPE, 0, 1'b0);
        add_row("1234567.,",       KIND_INT,    7, KIND_SHORT, 1'b0, 0, ST_VALUE, 0, 1'b0);
        add_row("-3.25\015",       KIND_SHORT,  5, KIND_INT,   1'b0, 1, ST_BAD_TYPE, 0, 1'b0);
        add_row("0.123456789,",    KIND_FULL,  11, KIND_SHORT, 1'b0, 1, ST_BAD_CHAR, 0, 1'b0);

        // directed arguments
        foreach (arg_rows[r])
        begin
            use_typed         = arg_rows[r].typed;
            typed.status      = arg_rows[r].status;
            typed.value       = arg_rows[r].value[50:0];
            typed.ended_by_cr = arg_rows[r].ended_by_cr;
            for (int i = 0; i < arg_rows[r].text.len(); i++)
            begin
                k = (i == arg_rows[r].alt_at) ? arg_rows[r].alt_kind : arg_rows[r].kind;
                send_char(arg_rows[r].text[i], k, arg_rows[r].last, use_typed, typed);
            end
        end
        hold_until_drained();

        // random arguments, with one full drain half way
        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 39) == 0)
                calm = ~calm;
            if (!paused && chars_sent > RANDOM_CHARS / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
            send_random_field();
        end
        s_tvalid <= 1'b0;

        // wait out the last results
        wait_cnt = 0;
        while (field_results_q.size() > 0 && wait_cnt < 2000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        if (field_results_q.size() > 0)
        begin
            $display("%0t %0d expected results never arrived",
                     $time, field_results_q.size());
            errors++;
        end
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/dpp_pkg.sv
sv/dpp_parse.sv
sv/dpp_scale.sv
sv/dpp_out.sv
sv/decimal_parameter_parser.sv
tb/sv/tb_decimal_parameter_parser.sv
